/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/fsoc_pkg.sv */
// ----------------------------------------------------------------------------
// fsoc_pkg
// Shared types and constants of the first-seen-order frequency counter.
// ----------------------------------------------------------------------------
package fsoc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int SLOT_W      = 6;
	localparam int TOTAL_W     = 7;
	localparam int VALUE_W     = 6;
	localparam int CNT_OUT_W   = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic insert;
		logic read_count;
		logic incr;
		logic emit;
		logic clear;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_range;
		logic seen;
		logic full;
		logic empty;
		logic last;
		logic emit_done;
	} status_t;

endpackage

/* hw/rtl/fsoc_ctrl.sv */
// ----------------------------------------------------------------------------
// fsoc_ctrl
// Sequencing state machine: update of one request, then the emission walk.
// ----------------------------------------------------------------------------
module fsoc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fsoc_pkg::status_t status,
	output fsoc_pkg::cmd_t    cmd,
	output logic              busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_INCR,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (status.in_range && status.seen) begin
					cmd.read_count = 1'b1;
					state_d        = ST_INCR;
				end else if (status.in_range && !status.full) begin
					cmd.insert = 1'b1;
					state_d    = status.last ? ST_EMIT : ST_IDLE;
				end else if (status.last && !status.empty) begin
					state_d = ST_EMIT;
				end else if (status.last) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_INCR: begin
				cmd.incr = 1'b1;
				state_d  = status.last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.emit_done) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

/* hw/rtl/fsoc_dp.sv */
// ----------------------------------------------------------------------------
// fsoc_dp
// Datapath: seen map, slot tables, count memory and the result registers.
// ----------------------------------------------------------------------------
module fsoc_dp #(
	parameter int VALUE_RANGE = 64,
	parameter int COUNT_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [fsoc_pkg::VALUE_W-1:0]        sample_value,
	input  logic                                set_end,
	input  fsoc_pkg::cmd_t                      cmd,
	output fsoc_pkg::status_t                   status,
	output logic                                result_valid,
	output logic [fsoc_pkg::VALUE_W-1:0]        distinct_value,
	output logic [fsoc_pkg::CNT_OUT_W-1:0]      occurrence_count,
	output logic                                final_pair
);

	localparam int VAL_IDX_W = $clog2(VALUE_RANGE);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// Captured request.
	logic [fsoc_pkg::VALUE_W-1:0] v_q;
	logic                         last_q;
	logic [fsoc_pkg::SLOT_W-1:0]  slot_q;

	// Control state.
	logic [VALUE_RANGE-1:0]       seen_q;
	logic [fsoc_pkg::TOTAL_W-1:0] total_q;
	logic [fsoc_pkg::SLOT_W-1:0]  emit_idx_q;
	logic                         strobe_q;
	logic                         final_q;

	// Memories and their read registers.
	logic [fsoc_pkg::SLOT_W-1:0]  slot_mem [VALUE_RANGE];
	logic [fsoc_pkg::VALUE_W-1:0] value_mem [fsoc_pkg::TABLE_DEPTH];
	logic [COUNT_BITS-1:0]        cnt_mem [fsoc_pkg::TABLE_DEPTH];
	logic [fsoc_pkg::VALUE_W-1:0] val_rd_q;
	logic [COUNT_BITS-1:0]        cnt_rd_q;

	logic [VAL_IDX_W-1:0]         in_idx;
	logic [fsoc_pkg::SLOT_W-1:0]  new_slot;
	logic [fsoc_pkg::SLOT_W-1:0]  cnt_wr_addr;
	logic [fsoc_pkg::SLOT_W-1:0]  cnt_rd_addr;
	logic [COUNT_BITS-1:0]        cnt_wr_data;
	logic                         emit_done;

	assign in_idx      = v_q[VAL_IDX_W-1:0];
	assign new_slot    = total_q[fsoc_pkg::SLOT_W-1:0];
	assign cnt_wr_addr = cmd.insert ? new_slot : slot_q;
	assign cnt_rd_addr = cmd.emit ? emit_idx_q : slot_q;
	assign cnt_wr_data = cmd.insert ? COUNT_BITS'(1) :
		((cnt_rd_q == CNT_MAX) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1));
	assign emit_done   = ((fsoc_pkg::TOTAL_W'(emit_idx_q) + fsoc_pkg::TOTAL_W'(1)) == total_q);

	assign status.in_range  = (fsoc_pkg::TOTAL_W'(v_q) < fsoc_pkg::TOTAL_W'(VALUE_RANGE));
	assign status.seen      = seen_q[in_idx];
	assign status.full      = (total_q == fsoc_pkg::TOTAL_W'(fsoc_pkg::TABLE_DEPTH));
	assign status.empty     = (total_q == '0);
	assign status.last      = last_q;
	assign status.emit_done = emit_done;

	// Request capture and slot lookup, issued on the accepting edge.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			v_q    <= sample_value;
			last_q <= set_end;
			slot_q <= slot_mem[sample_value[VAL_IDX_W-1:0]];
		end
		if (cmd.insert) begin
			slot_mem[in_idx] <= new_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			value_mem[new_slot] <= v_q;
		end
		if (cmd.emit) begin
			val_rd_q <= value_mem[emit_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert || cmd.incr) begin
			cnt_mem[cnt_wr_addr] <= cnt_wr_data;
		end
		if (cmd.read_count || cmd.emit) begin
			cnt_rd_q <= cnt_mem[cnt_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			total_q    <= '0;
			emit_idx_q <= '0;
			strobe_q   <= 1'b0;
			final_q    <= 1'b0;
		end else begin
			if (cmd.clear) begin
				seen_q     <= '0;
				total_q    <= '0;
				emit_idx_q <= '0;
			end else begin
				if (cmd.insert) begin
					seen_q[in_idx] <= 1'b1;
					total_q        <= total_q + fsoc_pkg::TOTAL_W'(1);
				end
				if (cmd.emit) begin
					emit_idx_q <= emit_idx_q + fsoc_pkg::SLOT_W'(1);
				end
			end
			strobe_q <= cmd.emit;
			final_q  <= cmd.emit && emit_done;
		end
	end

	assign result_valid     = strobe_q;
	assign distinct_value   = val_rd_q;
	assign occurrence_count = fsoc_pkg::CNT_OUT_W'(cnt_rd_q);
	assign final_pair       = final_q;

endmodule

/* hw/rtl/first_seen_order_frequency_count_core.sv */
// A first-seen value takes lookup and write; a repeated value lookup, count read and write.
// A new request is taken only once the current one, and any walk that it starts, is done.
// A marked request adds one result per cycle for each distinct value, then clears the set.
// The receiver cannot stall: each result is shown for exactly one cycle under result_valid.
// Reset (arst_n low) clears the seen map, the slot total and the controller at once.
// ----------------------------------------------------------------------------
// first_seen_order_frequency_count_core
// Histogram of small values, reported in order of first appearance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_seen_order_frequency_count_core #(
	parameter int VALUE_RANGE = 64,
	parameter int COUNT_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [fsoc_pkg::VALUE_W-1:0]   sample_value,
	input  logic                           set_end,
	output logic                           result_valid,
	output logic [fsoc_pkg::VALUE_W-1:0]   distinct_value,
	output logic [fsoc_pkg::CNT_OUT_W-1:0] occurrence_count,
	output logic                           final_pair
);

	// The controller sequences each request through a lookup of the value's
	// slot, an optional read of the slot count, and any write back of either
	// a fresh slot or the incremented count. A request that carries set_end
	// then walks every used slot, one result per cycle, and the last walk
	// step clears the seen map and the slot total for the next set.
	fsoc_pkg::cmd_t    cmd;
	fsoc_pkg::status_t status;

	fsoc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the seen map in flip-flops so that the whole map clears
	// at once, and keeps the slot index per value, the value per slot and the
	// count per slot in memories. Counts saturate at all ones; the result
	// port carries the low sixteen bits of a count.
	fsoc_dp #(
		.VALUE_RANGE (VALUE_RANGE),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_value     (sample_value),
		.set_end          (set_end),
		.cmd              (cmd),
		.status           (status),
		.result_valid     (result_valid),
		.distinct_value   (distinct_value),
		.occurrence_count (occurrence_count),
		.final_pair       (final_pair)
	);

	// An accepted request always makes the block busy in the cycle after it is taken.
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// The final flag only appears together with a result.
	`ASSERT_IMPLIES(a_final_with_valid, clk, arst_n, final_pair, result_valid)
	// Results of one set come out as an unbroken burst that ends on the final pair.
	`ASSERT_NEXT(a_burst_contiguous, clk, arst_n, result_valid && !final_pair, result_valid)
	// While a burst is still running the block refuses new requests.
	`ASSERT_IMPLIES(a_burst_busy, clk, arst_n, result_valid && !final_pair, busy)

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-seen-order frequency counter. Sets of
// values go in as requests, and a tally kept here predicts the (value, count)
// pairs that each marked request releases and checks them as they arrive.
// ----------------------------------------------------------------------------
module testbench;

	localparam int VALUE_W     = fsoc_pkg::VALUE_W;
	localparam int CNT_OUT_W   = fsoc_pkg::CNT_OUT_W;
	localparam int SLOT_W      = fsoc_pkg::SLOT_W;
	localparam int TABLE_DEPTH = fsoc_pkg::TABLE_DEPTH;

	// The block is built with its default sizes, and the tally mirrors them.
	localparam int VALUE_RANGE = 64;
	localparam int COUNT_BITS  = 16;
	// Least number of requests sent over the whole run, directed sets included.
	localparam int TOTAL_REQUESTS = 170;
	// Pairs follow a marked request one per cycle, so the drain outlasts a full set
	// of 64 pairs and the lookup before it.
	localparam int DRAIN_CYCLES = 80;
	// Even with the largest pauses on every request and a full set of 64 pairs
	// after each, the run would stay far inside the limit.
	localparam int CYCLE_LIMIT = 100_000;

	typedef struct packed {
		logic [VALUE_W-1:0]   value;
		logic [CNT_OUT_W-1:0] count;
		logic                 last;
	} pair_t;

	// Tally of the current set in order of first appearance, and the pairs
	// that the block still owes us.
	class first_seen_tally;
		bit [TABLE_DEPTH-1:0] seen_map;
		bit [SLOT_W-1:0]      slot_of[TABLE_DEPTH];
		bit [VALUE_W-1:0]     value_in_slot[TABLE_DEPTH];
		bit [COUNT_BITS-1:0]  slot_tally[TABLE_DEPTH];
		int unsigned          slots_used;
		pair_t                expected_pairs[$];
		int unsigned          mismatches;
		int unsigned          pairs_checked;

		function new();
			seen_map = '0;
			slots_used = 0;
			mismatches = 0;
			pairs_checked = 0;
		endfunction

		// Count one accepted request and, if it closes the set, queue every
		// pair of the set and start over.
		function void note_request(logic [VALUE_W-1:0] v, logic closes_set);
			bit [SLOT_W-1:0]    s;
			bit [CNT_OUT_W-1:0] shown;
			pair_t              p;
			if (int'(v) < VALUE_RANGE) begin
				if (!seen_map[v]) begin
					if (slots_used < TABLE_DEPTH) begin
						s = slots_used[SLOT_W-1:0];
						seen_map[v] = 1'b1;
						slot_of[v] = s;
						value_in_slot[s] = v;
						slot_tally[s] = COUNT_BITS'(1);
						slots_used++;
					end
				end else begin
					s = slot_of[v];
					if (slot_tally[s] != {COUNT_BITS{1'b1}})
						slot_tally[s] = slot_tally[s] + 1'b1;
				end
			end
			if (closes_set) begin
				for (int k = 0; k < slots_used; k++) begin
					// Only the low bits of a wide count reach the port.
					shown = CNT_OUT_W'(slot_tally[k]);
					p.value = value_in_slot[k];
					p.count = shown;
					p.last = (k + 1 == slots_used);
					expected_pairs = {expected_pairs, p};
				end
				seen_map = '0;
				slots_used = 0;
			end
		endfunction

		// Compare one pair from the block against the oldest one owed.
		function void check_pair(logic [VALUE_W-1:0] v, logic [CNT_OUT_W-1:0] c, logic f);
			pair_t want;
			if (expected_pairs.size() == 0) begin
				$error("unexpected pair: distinct_value %0d occurrence_count %0d final_pair %0b",
					v, c, f);
				mismatches++;
				return;
			end
			want = expected_pairs.pop_front();
			pairs_checked++;
			if (v !== want.value) begin
				$error("distinct_value: expected %0d, actual %0d", want.value, v);
				mismatches++;
			end
			if (c !== want.count) begin
				$error("occurrence_count: expected %0d, actual %0d", want.count, c);
				mismatches++;
			end
			if (f !== want.last) begin
				$error("final_pair: expected %0b, actual %0b", want.last, f);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [VALUE_W-1:0] sample_value = '0;
	logic               set_end = 1'b0;
	logic               busy;
	logic               result_valid;
	logic [VALUE_W-1:0]   distinct_value;
	logic [CNT_OUT_W-1:0] occurrence_count;
	logic                 final_pair;

	first_seen_tally book;
	int unsigned requests_sent = 0;
	int unsigned sets_sent = 0;
	int unsigned full_sets = 0;
	int unsigned cycles = 0;

	first_seen_order_frequency_count_core #(
		.VALUE_RANGE(VALUE_RANGE),
		.COUNT_BITS (COUNT_BITS)
	) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.sample_value    (sample_value),
		.set_end         (set_end),
		.result_valid    (result_valid),
		.distinct_value  (distinct_value),
		.occurrence_count(occurrence_count),
		.final_pair      (final_pair)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver cannot hold pairs off, so every strobe is checked on the
	// edge that closes its cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1)
			book.check_pair(distinct_value, occurrence_count, final_pair);
	end

	// Watchdog: a hung block or a lost pair ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[first_seen_order_frequency_count_core] ERROR");
			$finish;
		end
	end

	// Present one request after a random pause of up to max_gap cycles and
	// hold it until an edge finds busy low. When no pause is drawn, start
	// simply stays high and the next request follows at once.
	task automatic send_request(input logic [VALUE_W-1:0] v, input logic closes_set,
		input int max_gap);
		int gap;
		gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sample_value <= v;
		set_end <= closes_set;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		book.note_request(v, closes_set);
		requests_sent++;
	endtask

	// Send a whole set; the marker rides on its last value.
	task automatic send_set(input logic [VALUE_W-1:0] values[$], input int max_gap);
		for (int i = 0; i < values.size(); i++)
			send_request(values[i], i == values.size() - 1, max_gap);
		sets_sent++;
	endtask

	// All 64 values once in shuffled order, then a few repeats, so that the
	// slot list fills completely and the largest burst of pairs comes out.
	task automatic send_full_set(input int max_gap);
		logic [VALUE_W-1:0] order[$];
		logic [VALUE_W-1:0] swap;
		int j;
		for (int i = 0; i < TABLE_DEPTH; i++)
			order = {order, VALUE_W'(i)};
		for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		repeat ($urandom_range(0, 5))
			order = {order, VALUE_W'($urandom_range(0, VALUE_RANGE - 1))};
		send_set(order, max_gap);
		full_sets++;
	endtask

	initial begin
		logic [VALUE_W-1:0] batch[$];
		int max_gap;
		int pool_base;
		int kind;

		book = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets: single values at both ends of the range, repeats
		// mixed with first sightings, and alternating bit patterns.
		batch = '{6'd0};
		send_set(batch, 16);
		batch = '{6'd63};
		send_set(batch, 0);
		batch = '{6'd5, 6'd5, 6'd5, 6'd9, 6'd5, 6'd9, 6'd63};
		send_set(batch, 4);
		batch = '{6'd21, 6'd42, 6'd21, 6'd42, 6'd0};
		send_set(batch, 0);
		batch = '{6'd63, 6'd62, 6'd1, 6'd0, 6'd63};
		send_set(batch, 16);
		// A value seen in an earlier set must start again from one.
		batch = '{6'd42, 6'd7, 6'd42};
		send_set(batch, 2);

		// One full set, then random sets until the request budget is spent.
		// Some run with no pauses at all, the rest with random pauses on
		// every request.
		send_full_set(16);
		while (requests_sent < TOTAL_REQUESTS) begin
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 16;
			kind = $urandom_range(0, 11);
			batch.delete();
			if (kind <= 7) begin
				// Values from a narrow pool, so repeats are common.
				pool_base = $urandom_range(0, VALUE_RANGE - 4);
				repeat ($urandom_range(1, 10))
					batch = {batch, VALUE_W'(pool_base + $urandom_range(0, 3))};
				send_set(batch, max_gap);
			end else begin
				repeat ($urandom_range(1, 8))
					batch = {batch, VALUE_W'($urandom_range(0, VALUE_RANGE - 1))};
				send_set(batch, max_gap);
			end
		end
		start <= 1'b0;

		// Let the last pairs arrive, then watch a while for strays.
		while (book.expected_pairs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests in %0d sets, %0d of them filling all 64 slots.",
			requests_sent, sets_sent, full_sets);
		$display("Checked %0d pairs, %0d mismatches.", book.pairs_checked, book.mismatches);
		if (book.mismatches == 0)
			$display("[first_seen_order_frequency_count_core] OK");
		else
			$display("[first_seen_order_frequency_count_core] ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fsoc_pkg.sv
hw/rtl/fsoc_ctrl.sv
hw/rtl/fsoc_dp.sv
hw/rtl/first_seen_order_frequency_count_core.sv
tb/sv/testbench.sv
